// File: hdl/lidar_cylinder_detector_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lidar cylinder detector
// Shared assertion forms used by the controller.
// ----------------------------------------------------------------------------
`ifndef LIDAR_CYLINDER_DETECTOR_DEFINES_SVH
`define LIDAR_CYLINDER_DETECTOR_DEFINES_SVH

// assert that cond implies prop on the next edge
`define LCD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

// assert that cond implies prop on the same edge
`define LCD_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

`endif

// File: hdl/lcd_pkg.sv
// ----------------------------------------------------------------------------
// Lidar cylinder detector package
// Constants, command and status types, and the quarter sine table entry function.
// ----------------------------------------------------------------------------
package lcd_pkg;

   localparam int MAX_BEAMS_DEF        = 4096;
   localparam int SINE_TABLE_DEPTH_DEF = 1024;
   localparam int RANGE_BITS_DEF       = 16;
   localparam int CFG_BITS             = 16;
   localparam int CSR_IDX_BITS         = 3;
   localparam int SQ_BITS              = 36;

   localparam logic [CSR_IDX_BITS-1:0] REG_RANGE_MIN = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_RANGE_MAX = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_ANG_START = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_ANG_STEP  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAP       = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_TARGET    = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_TOL       = 3'd6;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ANGLE, ST_SINREAD, ST_MULX, ST_MULY, ST_ROUND,
      ST_DX, ST_DY, ST_DDEC, ST_CLOSE_X, ST_CLOSE_Y, ST_CLOSE_DEC,
      ST_DIV_X, ST_DIV_Y, ST_UPDATE, ST_FINISH, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;        // capture beam
      logic angle;       // compute angle
      logic sin_read;    // read sine magnitudes
      logic mul_x;       // range * cos
      logic mul_y;       // range * sin
      logic round_xy;    // round point
      logic sq_dx;       // square dx
      logic sq_dy;       // square dy
      logic cw_x;        // square width x
      logic cw_y;        // square width y
      logic div_start;   // begin centroid divide
      logic div_sel_y;   // divide y sum
      logic append;      // append point
      logic close;       // drop open cluster
      logic start;       // start new cluster
      logic finish;      // build result
      logic clear;       // clear scan
   } cmd_type;

   typedef struct packed {
      logic valid_beam;
      logic cluster_open;
      logic join_ok;
      logic close_match;
      logic div_done;
      logic last;
   } status_type;

   // round(65536*sin(k*pi/(2*depth))) by Q30 Taylor series
   function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned depth);
      logic [63:0] x;
      logic [63:0] term;
      longint      acc;
      logic [63:0] r;
      x = (64'(k) * 64'd1686629713) / 64'(depth);
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2*n) * (2*n+1));
         if (n % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      r = (64'(acc) + 64'd8192) >> 14;
      if (r > 64'd65535) r = 64'd65535;
      return r[15:0];
   endfunction

endpackage

// File: hdl/lcd_datapath.sv
// ----------------------------------------------------------------------------
// Lidar cylinder detector datapath
// Point conversion, cluster accumulation, width test and centroid divider.
// ----------------------------------------------------------------------------
module lcd_datapath #(
   parameter int MAX_BEAMS        = lcd_pkg::MAX_BEAMS_DEF,
   parameter int SINE_TABLE_DEPTH = lcd_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lcd_pkg::cmd_type              cmd,
   output lcd_pkg::status_type           status,
   input  logic [15:0]                   beam_range,
   input  logic [11:0]                   beam_index,
   input  logic                          beam_last,
   input  logic                          csr_we,
   input  logic [lcd_pkg::CSR_IDX_BITS-1:0] csr_idx,
   input  logic [lcd_pkg::CFG_BITS-1:0]  csr_wdata,
   output logic                          res_found,
   output logic signed [16:0]            res_x,
   output logic signed [16:0]            res_y
);
   localparam int RANGE_BITS = lcd_pkg::RANGE_BITS_DEF;
   localparam int TBITS = $clog2(SINE_TABLE_DEPTH);
   localparam int CBITS = $clog2(MAX_BEAMS + 1);
   localparam int SBITS = 17 + CBITS;

   // sine table as ROM, read through a registered port
   logic [15:0] sine_rom [SINE_TABLE_DEPTH];
   initial begin
      for (int k = 0; k < SINE_TABLE_DEPTH; k++)
         sine_rom[k] = lcd_pkg::sine_entry(k, SINE_TABLE_DEPTH);
   end

   logic [15:0] rmin_ff, rmax_ff, astart_ff, astep_ff, gap_ff, tgt_ff, tol_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rmin_ff <= 16'd0; rmax_ff <= 16'hFFFF; astart_ff <= 16'd0;
         astep_ff <= 16'd182; gap_ff <= 16'd100; tgt_ff <= 16'd300;
         tol_ff <= 16'd50;
      end else if (csr_we) begin
         case (csr_idx)
            lcd_pkg::REG_RANGE_MIN: rmin_ff   <= csr_wdata;
            lcd_pkg::REG_RANGE_MAX: rmax_ff   <= csr_wdata;
            lcd_pkg::REG_ANG_START: astart_ff <= csr_wdata;
            lcd_pkg::REG_ANG_STEP:  astep_ff  <= csr_wdata;
            lcd_pkg::REG_GAP:       gap_ff    <= csr_wdata;
            lcd_pkg::REG_TARGET:    tgt_ff    <= csr_wdata;
            lcd_pkg::REG_TOL:       tol_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [RANGE_BITS-1:0] range_ff;
   logic [11:0] idx_ff;
   logic        last_ff;
   logic [15:0] ang_ff;
   logic [15:0] srom_ff, crom_ff;
   logic        sfull_ff, cfull_ff;
   logic        cneg_ff, sneg_ff;
   logic [RANGE_BITS+16:0] prod_ff;
   logic signed [16:0] x_ff, y_ff;
   logic signed [16:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [SBITS-1:0] sum_x_ff, sum_y_ff;
   logic [CBITS-1:0] cnt_ff;
   logic        open_ff, match_ff;
   logic signed [16:0] mx_ff, my_ff;
   logic [lcd_pkg::SQ_BITS-1:0] sqa_ff, sqsum_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         range_ff <= beam_range[RANGE_BITS-1:0];
         idx_ff   <= beam_index;
         last_ff  <= beam_last;
      end
      if (cmd.angle) ang_ff <= astart_ff + 16'(idx_ff * astep_ff);
   end

   logic [15:0] cang;
   logic [14:0] us, uc;
   logic [TBITS-1:0] ai_s, ai_c;
   always_comb begin
      cang = ang_ff + 16'd16384;
      us = ang_ff[14] ? (15'd16384 - {1'b0, ang_ff[13:0]}) : {1'b0, ang_ff[13:0]};
      uc = cang[14] ? (15'd16384 - {1'b0, cang[13:0]}) : {1'b0, cang[13:0]};
      ai_s = TBITS'((29'(us[13:0]) * 29'(SINE_TABLE_DEPTH)) >> 14);
      ai_c = TBITS'((29'(uc[13:0]) * 29'(SINE_TABLE_DEPTH)) >> 14);
   end

   // a quarter angle of exactly a quarter turn reads full scale
   logic [16:0] smag, cmag;
   assign smag = sfull_ff ? 17'd65536 : {1'b0, srom_ff};
   assign cmag = cfull_ff ? 17'd65536 : {1'b0, crom_ff};

   always_ff @(posedge clock) begin
      if (cmd.sin_read) begin
         srom_ff <= sine_rom[ai_s]; sfull_ff <= us[14]; sneg_ff <= ang_ff[15];
         crom_ff <= sine_rom[ai_c]; cfull_ff <= uc[14]; cneg_ff <= cang[15];
      end
      if (cmd.mul_x) prod_ff <= range_ff * cmag;
      if (cmd.mul_y) begin
         prod_ff <= range_ff * smag;
      end
   end

   // round the product, sign applied by magnitude
   logic [RANGE_BITS+16:0] rnd;
   logic [16:0] rmag;
   always_comb begin
      rnd  = (prod_ff + (RANGE_BITS+17)'(32768)) >> 16;
      rmag = rnd[16:0];
   end
   always_ff @(posedge clock) begin
      if (cmd.mul_y) x_ff <= cneg_ff ? -$signed(rmag) : $signed(rmag);
      if (cmd.round_xy) y_ff <= sneg_ff ? -$signed(rmag) : $signed(rmag);
   end

   // squarer shared between neighbor distance and width
   logic signed [17:0] diff;
   always_comb begin
      diff = 18'sd0;
      if (cmd.sq_dx) diff = 18'(x_ff) - 18'(prev_x_ff);
      if (cmd.sq_dy) diff = 18'(y_ff) - 18'(prev_y_ff);
      if (cmd.cw_x)  diff = 18'(prev_x_ff) - 18'(first_x_ff);
      if (cmd.cw_y)  diff = 18'(prev_y_ff) - 18'(first_y_ff);
   end
   logic [17:0] dabs;
   assign dabs = diff[17] ? 18'(-diff) : 18'(diff);
   always_ff @(posedge clock) begin
      if (cmd.sq_dx || cmd.cw_x) sqa_ff <= 36'(dabs * dabs);
      if (cmd.sq_dy || cmd.cw_y) sqsum_ff <= sqa_ff + 36'(dabs * dabs);
   end

   logic [16:0] hi, lo;
   logic [lcd_pkg::SQ_BITS-1:0] gap2;
   always_comb begin
      gap2 = 36'(gap_ff * gap_ff);
      hi = 17'(tgt_ff) + 17'(tol_ff);
      lo = 17'(tgt_ff) - 17'(tol_ff);
   end
   // decide on the squared sum written in the cycle before
   logic join_ok, close_ok;
   always_comb begin
      join_ok  = (sqsum_ff < gap2) && (cnt_ff < CBITS'(MAX_BEAMS));
      close_ok = open_ff && (cnt_ff >= CBITS'(2)) && !match_ff
                 && (sqsum_ff < 36'(hi * hi))
                 && ((tgt_ff < tol_ff) || (sqsum_ff > 36'(lo[15:0] * lo[15:0])));
   end

   // restoring divider for centroid, one quotient bit per cycle
   logic [SBITS-1:0] dnum_ff, dquo_ff;
   logic [SBITS:0]   drem_ff;
   logic [$clog2(SBITS+1)-1:0] dcnt_ff;
   logic dneg_ff, dbusy_ff;
   logic signed [SBITS-1:0] dsrc;
   logic [SBITS:0] dtrial;
   assign dsrc = cmd.div_sel_y ? sum_y_ff : sum_x_ff;
   assign dtrial = {drem_ff[SBITS-1:0], dnum_ff[SBITS-1]};
   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         dneg_ff  <= dsrc[SBITS-1];
         dnum_ff  <= (dsrc[SBITS-1] ? SBITS'(-dsrc) : SBITS'(dsrc))
                     + SBITS'(cnt_ff >> 1);
         drem_ff  <= '0;
         dquo_ff  <= '0;
         dcnt_ff  <= '0;
         dbusy_ff <= 1'b1;
      end else if (dbusy_ff) begin
         dnum_ff <= dnum_ff << 1;
         if (dtrial >= (SBITS+1)'(cnt_ff)) begin
            drem_ff <= dtrial - (SBITS+1)'(cnt_ff);
            dquo_ff <= {dquo_ff[SBITS-2:0], 1'b1};
         end else begin
            drem_ff <= dtrial;
            dquo_ff <= {dquo_ff[SBITS-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 1'b1;
         if (dcnt_ff == ($clog2(SBITS+1))'(SBITS-1)) dbusy_ff <= 1'b0;
      end
   end
   logic signed [16:0] dres;
   assign dres = dneg_ff ? -$signed(dquo_ff[16:0]) : $signed(dquo_ff[16:0]);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         open_ff <= 1'b0; match_ff <= 1'b0; cnt_ff <= '0;
         mx_ff <= '0; my_ff <= '0;
      end else begin
         if (cmd.div_start && !cmd.div_sel_y) match_ff <= 1'b1;
         if (cmd.div_start && cmd.div_sel_y) mx_ff <= dres;
         if (cmd.finish && status.div_done && match_ff && cmd.div_sel_y) my_ff <= dres;
         if (cmd.close) open_ff <= 1'b0;
         if (cmd.append) begin
            prev_x_ff <= x_ff; prev_y_ff <= y_ff;
            sum_x_ff <= sum_x_ff + SBITS'(x_ff);
            sum_y_ff <= sum_y_ff + SBITS'(y_ff);
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.start) begin
            open_ff <= 1'b1;
            first_x_ff <= x_ff; first_y_ff <= y_ff;
            prev_x_ff <= x_ff; prev_y_ff <= y_ff;
            sum_x_ff <= SBITS'(x_ff); sum_y_ff <= SBITS'(y_ff);
            cnt_ff <= CBITS'(1);
         end
      end
   end

   assign status.valid_beam   = (16'(range_ff) >= rmin_ff) && (16'(range_ff) <= rmax_ff);
   assign status.cluster_open = open_ff;
   assign status.join_ok      = join_ok;
   assign status.close_match  = close_ok;
   assign status.div_done     = !dbusy_ff;
   assign status.last         = last_ff;

   assign res_found = match_ff;
   assign res_x     = mx_ff;
   assign res_y     = my_ff;
endmodule

// File: hdl/lcd_controller.sv
// ----------------------------------------------------------------------------
// Lidar cylinder detector controller
// Sequences one beam through conversion, clustering and result delivery.
// ----------------------------------------------------------------------------
`include "lidar_cylinder_detector_defines.svh"
module lcd_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output lcd_pkg::cmd_type    cmd,
   input  lcd_pkg::status_type status
);
   lcd_pkg::state_type state_ff, state_in;
   logic closing_last_ff, closing_last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcd_pkg::ST_IDLE;
         closing_last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         closing_last_ff <= closing_last_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      closing_last_in = closing_last_ff;
      cmd = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         lcd_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = lcd_pkg::ST_ANGLE;
            end
         end
         lcd_pkg::ST_ANGLE: begin
            cmd.angle = 1'b1;
            state_in = lcd_pkg::ST_SINREAD;
         end
         lcd_pkg::ST_SINREAD: begin
            if (status.valid_beam) begin
               cmd.sin_read = 1'b1;
               state_in = lcd_pkg::ST_MULX;
            end else begin
               state_in = lcd_pkg::ST_FINISH;
            end
         end
         lcd_pkg::ST_MULX: begin
            cmd.mul_x = 1'b1;
            state_in = lcd_pkg::ST_MULY;
         end
         lcd_pkg::ST_MULY: begin
            cmd.mul_y = 1'b1;
            state_in = lcd_pkg::ST_ROUND;
         end
         lcd_pkg::ST_ROUND: begin
            cmd.round_xy = 1'b1;
            state_in = lcd_pkg::ST_DX;
         end
         lcd_pkg::ST_DX: begin
            if (status.cluster_open) begin
               cmd.sq_dx = 1'b1;
               state_in = lcd_pkg::ST_DY;
            end else begin
               cmd.start = 1'b1;
               state_in = lcd_pkg::ST_FINISH;
            end
         end
         lcd_pkg::ST_DY: begin
            cmd.sq_dy = 1'b1;
            state_in = lcd_pkg::ST_DDEC;
         end
         lcd_pkg::ST_DDEC: begin
            if (status.join_ok) begin
               cmd.append = 1'b1;
               state_in = lcd_pkg::ST_FINISH;
            end else begin
               closing_last_in = 1'b0;
               state_in = lcd_pkg::ST_CLOSE_X;
            end
         end
         lcd_pkg::ST_CLOSE_X: begin
            cmd.cw_x = 1'b1;
            state_in = lcd_pkg::ST_CLOSE_Y;
         end
         lcd_pkg::ST_CLOSE_Y: begin
            cmd.cw_y = 1'b1;
            state_in = lcd_pkg::ST_CLOSE_DEC;
         end
         lcd_pkg::ST_CLOSE_DEC: begin
            if (status.close_match) begin
               cmd.div_start = 1'b1;
               state_in = lcd_pkg::ST_DIV_X;
            end else begin
               state_in = lcd_pkg::ST_UPDATE;
            end
         end
         lcd_pkg::ST_DIV_X: begin
            if (status.div_done) begin
               // latch x quotient, start y divide
               cmd.div_start = 1'b1;
               cmd.div_sel_y = 1'b1;
               state_in = lcd_pkg::ST_DIV_Y;
            end
         end
         lcd_pkg::ST_DIV_Y: begin
            cmd.div_sel_y = 1'b1;
            if (status.div_done) begin
               cmd.finish = 1'b1;
               state_in = lcd_pkg::ST_UPDATE;
            end
         end
         lcd_pkg::ST_UPDATE: begin
            // close drops the cluster and, if a beam waits, start opens a new one in the same cycle
            cmd.close = 1'b1;
            if (closing_last_ff) begin
               state_in = lcd_pkg::ST_OUT;
            end else begin
               cmd.start = 1'b1;
               state_in = lcd_pkg::ST_FINISH;
            end
         end
         lcd_pkg::ST_FINISH: begin
            if (status.last) begin
               closing_last_in = 1'b1;
               state_in = lcd_pkg::ST_CLOSE_X;
            end else begin
               state_in = lcd_pkg::ST_IDLE;
            end
         end
         lcd_pkg::ST_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               cmd.clear = 1'b1;
               closing_last_in = 1'b0;
               state_in = lcd_pkg::ST_IDLE;
            end
         end
         default: state_in = lcd_pkg::ST_IDLE;
      endcase
   end

   `LCD_ASSERT_NOW(a_ready_idle, clock, reset, in_ready, !out_valid)
   `LCD_ASSERT_NEXT(a_load_angle, clock, reset, cmd.load, state_ff == lcd_pkg::ST_ANGLE)
   `LCD_ASSERT_NEXT(a_out_hold, clock, reset, out_valid && !out_ready, out_valid)
endmodule

// File: hdl/lidar_cylinder_detector.sv
// ----------------------------------------------------------------------------
// Lidar cylinder detector
// Breakpoint segmentation of a laser scan with cylinder width matching.
// ----------------------------------------------------------------------------
// One beam is taken per req_ beat and processed alone: a beam outside the
// range limits skips conversion, one that joins a cluster is appended, one
// that breaks a cluster closes it and starts a new one, and a close on a
// match runs one restoring divider for x and then y to form the centroid. A
// last beam adds the final close and the result hand-off. The beam converter
// uses one product register for x and y and one shared squarer, and the sine
// table is a constant ROM with a registered read. A single rsp_ beat follows
// the last beam from an output register, so the next scan may start while the
// beat waits; a later last beam holds only if that register is still full.
module lidar_cylinder_detector #(
   parameter int MAX_BEAMS        = lcd_pkg::MAX_BEAMS_DEF,
   parameter int SINE_TABLE_DEPTH = lcd_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // range_mm[15:0], beam_index[27:16], zero pad
   input  logic        req_tlast,   // last_beam
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // found[0], center_x_mm[17:1], center_y_mm[34:18]
   input  logic        csr_we,
   input  logic [lcd_pkg::CSR_IDX_BITS-1:0] csr_idx,
   input  logic [lcd_pkg::CFG_BITS-1:0]     csr_wdata
);
   lcd_pkg::cmd_type    cmd;
   lcd_pkg::status_type status;
   logic found;
   logic signed [16:0] cx, cy;
   logic res_valid, res_ready;
   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;

   lcd_controller u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(res_valid), .out_ready(res_ready),
      .cmd(cmd), .status(status)
   );

   lcd_datapath #(
      .MAX_BEAMS(MAX_BEAMS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .beam_range(req_tdata[15:0]), .beam_index(req_tdata[27:16]),
      .beam_last(req_tlast),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata),
      .res_found(found), .res_x(cx), .res_y(cy)
   );

   // hold the result beat; take a new one once the old one is gone
   assign res_ready = !rsp_valid_ff || rsp_tready;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
         // zero the centers when nothing matched
         rsp_data_ff  <= {5'd0, found ? cy : 17'sd0, found ? cx : 17'sd0, found};
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
